// ----- src/srms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_pkg: shared types and constants of the stereo RMS level meter
// Widths, register map, payload structs and back-end state encoding.
// ----------------------------------------------------------------------------
package srms_pkg;

  // Sample and level formats
  localparam int SampleW = 16;
  localparam int LevelW  = 16;
  localparam int ProdW   = 2 * LevelW;

  // Buffer limits and accumulator
  localparam int MaxPairs = 4096;
  localparam int PairCntW = $clog2(MaxPairs + 1);
  localparam int SumW     = 42;
  localparam int SqW      = 2 * SampleW - 2;

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 2);

  // Shared iterative divider
  localparam int DivNumW = SumW + 1;
  localparam int DivDenW = (PairCntW > LevelW) ? PairCntW : LevelW;
  localparam int DivCntW = $clog2(DivNumW + 1);

  // Square root unit
  localparam int RadW      = 2 * LevelW;
  localparam int RootW     = LevelW;
  localparam int SqrtRemW  = RootW + 1;
  localparam int SqrtStepW = $clog2(RootW);

  // Moving average datapath
  localparam int EmaW = 2 * LevelW + 1;

  // Register port
  localparam int RegW  = 32;
  localparam int AddrW = 3;
  localparam logic RegSmoothing = 1'b0;
  localparam logic RegFullScale = 1'b1;
  localparam logic [LevelW-1:0] SmoothingRst = 16'd4588;
  localparam logic [LevelW-1:0] FullScaleRst = 16'd11141;

  typedef struct packed {
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
    logic                      last_of_buffer;
  } in_t;

  typedef struct packed {
    logic [LevelW-1:0] buffer_rms;
    logic [LevelW-1:0] smoothed_level;
    logic [LevelW-1:0] scaled_level;
    logic [LevelW-1:0] buffers_seen;
  } out_t;

  // One finished buffer waiting for the back end
  typedef struct packed {
    logic [SumW-1:0]     sum;
    logic [PairCntW-1:0] pairs;
  } buf_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkDivRms,
    BkSqrt,
    BkMulOld,
    BkMulNew,
    BkDivStart,
    BkDivScl,
    BkOut
  } back_state_e;

endpackage

// ----- src/stereo_rms_level_meter_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_rms_level_meter_core: stereo RMS level meter with smoothing
// Input channel takes one stereo pair per transfer; output channel gives
// buffer RMS, smoothed level, scaled level and buffer count per buffer.
//
// Usage:
// - The input channel accepts one pair per cycle while the queue has room.
//   Each pair is squared in stage 1 and accumulated in stage 2; a pair marked
//   last of buffer closes the buffer and pushes it into a four-entry queue.
// - The back end takes one buffer at a time: a divide, a square root, two
//   multiply steps, a second divide and the output load.
// - Buffers that arrive faster than the back end finishes them fill the
//   queue, and the input then stalls on a pair until the back end frees an
//   entry.
// - The result is held in an output register; while the receiver stalls,
//   the back end waits at the load and the queue keeps filling.
// - Reset clears the accumulator, average, buffer count and queue, and
//   loads the register defaults; no clearing pass is needed.
// - Write registers over the APB port only while idle; the block won't check.
// ----------------------------------------------------------------------------
module stereo_rms_level_meter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  srms_pkg::in_t               in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output srms_pkg::out_t              out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srms_pkg::AddrW-1:0]  paddr,
  input  logic [srms_pkg::RegW-1:0]   pwdata,
  output logic [srms_pkg::RegW-1:0]   prdata,
  output logic                        pready
);

  logic [srms_pkg::LevelW-1:0]   weight_q;
  logic [srms_pkg::LevelW-1:0]   fscale_q;
  logic                          reg_wr;
  logic                          q_push;
  srms_pkg::buf_t                q_wdata;
  logic                          q_pop;
  srms_pkg::buf_t                q_rdata;
  logic                          q_empty;
  logic [srms_pkg::FifoCntW-1:0] q_cnt;
  srms_pkg::div_req_t            div_req;
  srms_pkg::div_rsp_t            div_rsp;

  // Register writes on the access phase
  assign pready = 1'b1;
  assign reg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= srms_pkg::SmoothingRst;
      fscale_q <= srms_pkg::FullScaleRst;
    end else if (reg_wr) begin
      if (paddr[2] == srms_pkg::RegSmoothing) begin
        weight_q <= pwdata[srms_pkg::LevelW-1:0];
      end else begin
        fscale_q <= pwdata[srms_pkg::LevelW-1:0];
      end
    end
  end

  // Register read-back
  always_comb begin
    prdata = '0;
    case (paddr[2])
      srms_pkg::RegSmoothing: prdata = srms_pkg::RegW'(weight_q);
      srms_pkg::RegFullScale: prdata = srms_pkg::RegW'(fscale_q);
      default:                prdata = '0;
    endcase
  end

  srms_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_cnt_i    (q_cnt),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  srms_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .cnt_o   (q_cnt)
  );

  srms_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  srms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .weight_i    (weight_q),
    .fscale_i    (fscale_q),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- src/srms_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_front: sample pair intake and square accumulation
// Takes one pair per cycle while the queue has room, squares halved samples
// and accumulates them; a last pair queues the buffer's sum and pair count.
// ----------------------------------------------------------------------------
module srms_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  srms_pkg::in_t                 in_data_i,
  input  logic [srms_pkg::FifoCntW-1:0] q_cnt_i,
  output logic                          q_push_o,
  output srms_pkg::buf_t                q_data_o
);

  logic                            accept;
  logic                            room;
  logic                            pend;
  logic [srms_pkg::SampleW-1:0]    mag_l;
  logic [srms_pkg::SampleW-1:0]    mag_r;
  logic [2*srms_pkg::SampleW-1:0]  sq_full_l;
  logic [2*srms_pkg::SampleW-1:0]  sq_full_r;
  logic [srms_pkg::PairCntW-1:0]   pairs_q, pairs_d;
  logic [srms_pkg::PairCntW-1:0]   pairs_inc;
  logic                            s1_valid_q;
  logic                            s1_last_q;
  logic [srms_pkg::PairCntW-1:0]   s1_pairs_q;
  logic [srms_pkg::SqW-1:0]        sq_l_q;
  logic [srms_pkg::SqW-1:0]        sq_r_q;
  logic [srms_pkg::SumW-1:0]       sum_q, sum_d;
  logic [srms_pkg::SumW:0]         sum_wide;
  logic [srms_pkg::SumW-1:0]       sum_sat;

  // Hold off a new pair while the queue could overflow
  assign pend       = s1_valid_q & s1_last_q;
  assign in_ready_o = (q_cnt_i + srms_pkg::FifoCntW'(pend)) <
                      srms_pkg::FifoCntW'(srms_pkg::FifoDepth);
  assign accept     = in_valid_i & in_ready_o;

  // Count pairs up to the limit; extra pairs add nothing
  assign room      = pairs_q < srms_pkg::PairCntW'(srms_pkg::MaxPairs);
  assign pairs_inc = pairs_q + srms_pkg::PairCntW'(room);
  assign pairs_d   = in_data_i.last_of_buffer ? '0 : pairs_inc;

  // Magnitudes and squares of the samples
  assign mag_l = in_data_i.left_sample[srms_pkg::SampleW-1] ?
                 srms_pkg::SampleW'(-in_data_i.left_sample) :
                 srms_pkg::SampleW'(in_data_i.left_sample);
  assign mag_r = in_data_i.right_sample[srms_pkg::SampleW-1] ?
                 srms_pkg::SampleW'(-in_data_i.right_sample) :
                 srms_pkg::SampleW'(in_data_i.right_sample);
  assign sq_full_l = mag_l * mag_l;
  assign sq_full_r = mag_r * mag_r;

  // Stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_q    <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        pairs_q   <= pairs_d;
        s1_last_q <= in_data_i.last_of_buffer;
      end
    end
  end

  // Stage 1 payload: quarter squares, dropped past the pair limit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pairs_q <= pairs_inc;
      sq_l_q     <= room ? sq_full_l[2*srms_pkg::SampleW-1:2] : '0;
      sq_r_q     <= room ? sq_full_r[2*srms_pkg::SampleW-1:2] : '0;
    end
  end

  // Stage 2: accumulate with saturation
  assign sum_wide = {1'b0, sum_q} + (srms_pkg::SumW + 1)'(sq_l_q) +
                    (srms_pkg::SumW + 1)'(sq_r_q);
  assign sum_sat  = sum_wide[srms_pkg::SumW] ? '1 : sum_wide[srms_pkg::SumW-1:0];
  assign sum_d    = s1_last_q ? '0 : sum_sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_valid_q) begin
      sum_q <= sum_d;
    end
  end

  // Push the finished buffer
  assign q_push_o       = pend;
  assign q_data_o.sum   = sum_sat;
  assign q_data_o.pairs = s1_pairs_q;

endmodule

// ----- src/srms_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_fifo: short queue of finished buffers
// Decouples the per-sample front end from the per-buffer back end.
// ----------------------------------------------------------------------------
module srms_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  srms_pkg::buf_t                data_i,
  input  logic                          pop_i,
  output srms_pkg::buf_t                data_o,
  output logic                          empty_o,
  output logic [srms_pkg::FifoCntW-1:0] cnt_o
);

  srms_pkg::buf_t                mem_q [srms_pkg::FifoDepth];
  logic [srms_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [srms_pkg::FifoCntW-1:0] cnt_q;

  function automatic logic [srms_pkg::FifoPtrW-1:0] ptr_next(
    input logic [srms_pkg::FifoPtrW-1:0] p
  );
    return (p == srms_pkg::FifoPtrW'(srms_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Write entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;

  // Never push into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (cnt_q < srms_pkg::FifoCntW'(srms_pkg::FifoDepth)))
    else $error("push into full buffer queue");

  // Never pop an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (cnt_q != '0))
    else $error("pop from empty buffer queue");

  // Push without pop grows the count by one
  a_cnt_grow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ----- src/srms_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_div: iterative restoring divider
// One quotient bit per cycle; shared by the RMS and full-scale divisions.
// ----------------------------------------------------------------------------
module srms_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srms_pkg::div_req_t req_i,
  output srms_pkg::div_rsp_t rsp_o
);

  logic [srms_pkg::DivNumW-1:0] num_q;
  logic [srms_pkg::DivDenW-1:0] den_q;
  logic [srms_pkg::DivDenW-1:0] rem_q;
  logic [srms_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;
  logic [srms_pkg::DivDenW:0]   rem_sh;
  logic [srms_pkg::DivDenW:0]   rem_sub;
  logic                         ge;

  // One restoring step
  assign rem_sh  = {rem_q, num_q[srms_pkg::DivNumW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= srms_pkg::DivCntW'(srms_pkg::DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == srms_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in quotient bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[srms_pkg::DivNumW-2:0], ge};
      rem_q <= ge ? rem_sub[srms_pkg::DivDenW-1:0] : rem_sh[srms_pkg::DivDenW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;

endmodule

// ----- src/srms_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srms_back: per-buffer level computation
// Divides, takes the square root, updates the moving average, scales
// against full scale and holds the result in the output register.
// ----------------------------------------------------------------------------
module srms_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srms_pkg::LevelW-1:0] weight_i,
  input  logic [srms_pkg::LevelW-1:0] fscale_i,
  input  logic                        q_empty_i,
  input  srms_pkg::buf_t              q_data_i,
  output logic                        q_pop_o,
  output srms_pkg::div_req_t          div_req_o,
  input  srms_pkg::div_rsp_t          div_rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output srms_pkg::out_t              out_data_o
);

  srms_pkg::back_state_e state_q, state_d;

  logic                           div_start;
  logic [srms_pkg::DivNumW-1:0]   div_num;
  logic [srms_pkg::DivDenW-1:0]   div_den;
  logic                           rad_take;
  logic                           sqrt_step;
  logic                           mul_old;
  logic                           mul_new;
  logic                           scl_take;
  logic                           out_load;

  logic                           pairs_zero_q;
  logic [srms_pkg::RadW-1:0]      rad_q;
  logic [srms_pkg::RootW-1:0]     root_q;
  logic [srms_pkg::SqrtRemW-1:0]  rem_q;
  logic [srms_pkg::SqrtStepW-1:0] sqrt_cnt_q;
  logic [srms_pkg::SqrtRemW+1:0]  rem_sh;
  logic [srms_pkg::SqrtRemW+1:0]  trial;
  logic [srms_pkg::SqrtRemW+1:0]  rem_sub;
  logic                           sq_ge;

  logic [srms_pkg::LevelW-1:0]    rms_q;
  logic [srms_pkg::LevelW-1:0]    avg_q;
  logic [srms_pkg::LevelW-1:0]    scaled_q;
  logic [srms_pkg::LevelW-1:0]    tally_q;
  logic [srms_pkg::LevelW:0]      w_comp;
  logic [srms_pkg::EmaW-1:0]      prod_q;
  logic [srms_pkg::EmaW-1:0]      ema_sum;
  logic [srms_pkg::LevelW:0]      ema_hi;
  logic [srms_pkg::ProdW-1:0]     scl_prod;
  logic                           out_valid_q;
  srms_pkg::out_t                 out_data_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      srms_pkg::BkIdle: begin
        if (!q_empty_i) state_d = srms_pkg::BkDivRms;
      end
      srms_pkg::BkDivRms: begin
        if (div_rsp_i.done) state_d = srms_pkg::BkSqrt;
      end
      srms_pkg::BkSqrt: begin
        if (sqrt_cnt_q == srms_pkg::SqrtStepW'(srms_pkg::RootW - 1)) begin
          state_d = srms_pkg::BkMulOld;
        end
      end
      srms_pkg::BkMulOld:   state_d = srms_pkg::BkMulNew;
      srms_pkg::BkMulNew:   state_d = srms_pkg::BkDivStart;
      srms_pkg::BkDivStart: state_d = srms_pkg::BkDivScl;
      srms_pkg::BkDivScl: begin
        if (div_rsp_i.done) state_d = srms_pkg::BkOut;
      end
      srms_pkg::BkOut: begin
        if (!out_valid_q || out_ready_i) state_d = srms_pkg::BkIdle;
      end
      default: state_d = srms_pkg::BkIdle;
    endcase
  end

  // Full-scale numerator: smoothed level times 65535
  assign scl_prod = {avg_q, {srms_pkg::LevelW{1'b0}}} - srms_pkg::ProdW'(avg_q);

  // Control strobes per state
  always_comb begin
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    rad_take  = 1'b0;
    sqrt_step = 1'b0;
    mul_old   = 1'b0;
    mul_new   = 1'b0;
    scl_take  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      srms_pkg::BkIdle: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          div_start = 1'b1;
          div_num   = {q_data_i.sum, 1'b0};
          div_den   = srms_pkg::DivDenW'(q_data_i.pairs);
        end
      end
      srms_pkg::BkDivRms:   rad_take  = div_rsp_i.done;
      srms_pkg::BkSqrt:     sqrt_step = 1'b1;
      srms_pkg::BkMulOld:   mul_old   = 1'b1;
      srms_pkg::BkMulNew:   mul_new   = 1'b1;
      srms_pkg::BkDivStart: begin
        div_start = 1'b1;
        div_num   = srms_pkg::DivNumW'(scl_prod);
        div_den   = srms_pkg::DivDenW'(fscale_i);
      end
      srms_pkg::BkDivScl:   scl_take  = div_rsp_i.done;
      srms_pkg::BkOut:      out_load  = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign div_req_o.start = div_start;
  assign div_req_o.num   = div_num;
  assign div_req_o.den   = div_den;

  // One square root step: two radicand bits per cycle
  assign rem_sh  = {rem_q, rad_q[srms_pkg::RadW-1 -: 2]};
  assign trial   = (srms_pkg::SqrtRemW + 2)'({root_q, 2'b01});
  assign sq_ge   = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  // Moving average: old share, then new share with rounding
  assign w_comp  = {1'b1, {srms_pkg::LevelW{1'b0}}} - (srms_pkg::LevelW + 1)'(weight_i);
  assign ema_sum = prod_q + srms_pkg::EmaW'(rms_q) * srms_pkg::EmaW'(weight_i) +
                   srms_pkg::EmaW'(1 << (srms_pkg::LevelW - 1));
  assign ema_hi  = ema_sum[srms_pkg::EmaW-1:srms_pkg::LevelW];

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srms_pkg::BkIdle;
      sqrt_cnt_q  <= '0;
      avg_q       <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rad_take) begin
        sqrt_cnt_q <= '0;
      end else if (sqrt_step) begin
        sqrt_cnt_q <= sqrt_cnt_q + 1'b1;
      end
      if (mul_new) begin
        avg_q <= ema_hi[srms_pkg::LevelW] ? '1 : ema_hi[srms_pkg::LevelW-1:0];
      end
      if (out_load) begin
        tally_q     <= tally_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      pairs_zero_q <= (q_data_i.pairs == '0);
    end
    if (rad_take) begin
      rad_q  <= div_rsp_i.quot[srms_pkg::RadW-1:0];
      root_q <= '0;
      rem_q  <= '0;
    end else if (sqrt_step) begin
      rad_q  <= {rad_q[srms_pkg::RadW-3:0], 2'b00};
      root_q <= {root_q[srms_pkg::RootW-2:0], sq_ge};
      rem_q  <= sq_ge ? rem_sub[srms_pkg::SqrtRemW-1:0] : rem_sh[srms_pkg::SqrtRemW-1:0];
    end
    if (mul_old) begin
      rms_q  <= pairs_zero_q ? '0 : root_q;
      prod_q <= srms_pkg::EmaW'(avg_q) * srms_pkg::EmaW'(w_comp);
    end
    if (scl_take) begin
      if (fscale_i == '0) begin
        scaled_q <= '0;
      end else if (|div_rsp_i.quot[srms_pkg::DivNumW-1:srms_pkg::LevelW]) begin
        scaled_q <= '1;
      end else begin
        scaled_q <= div_rsp_i.quot[srms_pkg::LevelW-1:0];
      end
    end
    if (out_load) begin
      out_data_q.buffer_rms     <= rms_q;
      out_data_q.smoothed_level <= avg_q;
      out_data_q.scaled_level   <= scaled_q;
      out_data_q.buffers_seen   <= tally_q + 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Divider is only started when free
  a_div_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_rsp_i.busy)
    else $error("divider started while busy");

  // A loaded result is presented next cycle
  a_out_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("loaded result not presented");

  // A fresh result carries the current smoothed level
  a_out_avg : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_data_q.smoothed_level == avg_q))
    else $error("result smoothed level differs from average");

endmodule
